@@ design/mrc_pkg.sv @@
package mrc_pkg;

  // Field and register widths
  localparam int MODE_W  = 2;
  localparam int RAW_W   = 32;
  localparam int VALUE_W = 40;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = 34;
  localparam int PULSE_W = 24;
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 5;

  // Serial multiplier datapath: radix-4 shift-add
  localparam int MCAND_W = 24;           // widest multiplicand (pulse count)
  localparam int ACC_W   = MCAND_W + 2;  // running upper partial product
  localparam int MUL_W   = 56;           // multiplier / low product shift register
  localparam int CNT_W   = 5;
  localparam int DIV_W   = 14;           // voltage quotient path, value below 15005

  // Digit steps per multiply (two multiplier bits per step)
  localparam int RMS_STEPS = 16;         // 32-bit reading
  localparam int E1_STEPS  = 8;          // 16-bit pulse constant
  localparam int E2_STEPS  = 16;         // 32-bit coefficient product
  localparam int E3_STEPS  = 28;         // 56-bit pulse product

  localparam logic [COEF_W-1:0] COEF_BAD        = 16'hFFFF;
  localparam logic [COEF_W-1:0] ENERGY_COEF_RST = 16'hFFFF;
  localparam logic [17:0]       ENERGY_NUM      = 18'd140625;
  localparam logic [20:0]       NOISE_FLOOR     = 21'd20;
  localparam logic [20:0]       POWER_MAX       = 21'd65535;
  localparam logic [25:0]       VOLT_Y_FAIL     = 26'd15005;  // 5 * 3001
  localparam logic [3:0]        DIV_BY          = 4'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_POWER   = 2'd0,
    MODE_CURRENT = 2'd1,
    MODE_VOLTAGE = 2'd2,
    MODE_ENERGY  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_POWER_COEF   = 3'd0,
    REG_CURRENT_COEF = 3'd1,
    REG_VOLTAGE_COEF = 3'd2,
    REG_ENERGY_COEF  = 3'd3,
    REG_PULSE_CONST  = 3'd4
  } reg_idx_t;

  function automatic logic coef_invalid(input logic [COEF_W-1:0] c);
    coef_invalid = (c == '0) || (c == COEF_BAD);
  endfunction

endpackage

@@ design/mrc_if.sv @@
interface mrc_in_if;
  import mrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [RAW_W-1:0]   raw_reading;

  modport source (output valid, output mode, output raw_reading, input ready);
  modport sink   (input valid, input mode, input raw_reading, output ready);
endinterface

interface mrc_out_if;
  import mrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

@@ design/meter_reading_converter_core.sv @@
// Paths: bad coefficients, zero flags and idle energy go straight to the result; power, current
// and voltage over range take one radix-4 shift-add multiply, voltage in range adds the serial
// divide-by-5, and energy chains three multiplies. A new reading is taken only once the last
// one has been handed to the output register, which frees the core while a beat waits there.
// Reset (rst_n, synchronous, active low):
// coefficients to their defaults, energy fraction to zero, pipeline idle, output empty.
module meter_reading_converter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mrc_in_if.sink                        in_ch,
  mrc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrc_pkg::APB_DW-1:0]    pwdata,
  output logic [mrc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import mrc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_POST = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // Which multiply is running; energy chains three of them
  typedef enum logic [5:0] {
    PH_PWR  = 6'b000001,
    PH_CUR  = 6'b000010,
    PH_VOLT = 6'b000100,
    PH_E1   = 6'b001000,  // energy_coef * pulse_const
    PH_E2   = 6'b010000,  // pulses * (energy_coef * pulse_const)
    PH_E3   = 6'b100000   // pulse product * 140625 + fraction
  } phase_t;

  // Configuration
  logic [COEF_W-1:0]  power_coef_r, power_coef_nxt;
  logic [COEF_W-1:0]  current_coef_r, current_coef_nxt;
  logic [COEF_W-1:0]  voltage_coef_r, voltage_coef_nxt;
  logic [COEF_W-1:0]  energy_coef_r, energy_coef_nxt;
  logic [COEF_W-1:0]  pulse_const_r, pulse_const_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;

  // Control
  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Datapath
  logic [ACC_W-1:0]   hi_r, hi_nxt;
  logic [MUL_W-1:0]   lo_r, lo_nxt;
  logic [MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [FRAC_W-1:0]  fshift_r, fshift_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [2:0]         rem_r, rem_nxt;
  logic [PULSE_W-1:0] p_r, p_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic               res_status_r, res_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_status_r, out_status_nxt;

  // Combinational helpers
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;
  logic [RAW_W-1:0]         mag;
  logic [19:0]              coef10;
  logic [PULSE_W-1:0]       pulses;
  logic [1:0]               fdig;
  logic [ACC_W-1:0]         sum;
  logic [ACC_W+MUL_W-1:0]   prod;
  logic [20:0]              pwr_v;
  logic [24:0]              cur_v;
  logic [26:0]              volt_sum;
  logic [25:0]              volt_y;
  logic [3:0]               dt;
  logic [3:0]               dsub;
  logic                     dge;
  logic [DIV_W-1:0]         div_step;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  // Power magnitude; the most negative reading maps to 2^31 on its own
  assign mag    = in_ch.raw_reading[RAW_W-1] ? (~in_ch.raw_reading + 1'b1) : in_ch.raw_reading;
  assign coef10 = {1'b0, power_coef_r, 3'b000} + {3'b000, power_coef_r, 1'b0};
  assign pulses = in_ch.raw_reading[PULSE_W-1:0];

  // Radix-4 step: add 0..3 times the multiplicand, plus a fraction digit in the last multiply
  assign fdig = (phase_r == PH_E3) ? fshift_r[1:0] : 2'b00;
  assign sum  = hi_r
              + (lo_r[0] ? {2'b00, mcand_r} : {ACC_W{1'b0}})
              + (lo_r[1] ? {1'b0, mcand_r, 1'b0} : {ACC_W{1'b0}})
              + {{(ACC_W-2){1'b0}}, fdig};

  // After n steps, product bit j sits at prod[j + MUL_W - 2n]
  assign prod     = {hi_r, lo_r};
  assign pwr_v    = {1'b0, prod[75:56]} + {20'd0, prod[55]};      // round at bit 31
  assign cur_v    = {1'b0, prod[71:48]} + {24'd0, prod[47]};      // round at bit 23
  assign volt_sum = {1'b0, prod[71:46]} + 27'd5;                  // + 5*2^22, then >> 23
  assign volt_y   = volt_sum[26:1];

  // Restoring divide by 5, one quotient bit a cycle
  assign dt       = {rem_r, div_r[DIV_W-1]};
  assign dge      = (dt >= DIV_BY);
  assign dsub     = dt - DIV_BY;
  assign div_step = {div_r[DIV_W-2:0], dge};

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_POWER_COEF:   prdata = {{(APB_DW-COEF_W){1'b0}}, power_coef_r};
      REG_CURRENT_COEF: prdata = {{(APB_DW-COEF_W){1'b0}}, current_coef_r};
      REG_VOLTAGE_COEF: prdata = {{(APB_DW-COEF_W){1'b0}}, voltage_coef_r};
      REG_ENERGY_COEF:  prdata = {{(APB_DW-COEF_W){1'b0}}, energy_coef_r};
      REG_PULSE_CONST:  prdata = {{(APB_DW-COEF_W){1'b0}}, pulse_const_r};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    power_coef_nxt   = power_coef_r;
    current_coef_nxt = current_coef_r;
    voltage_coef_nxt = voltage_coef_r;
    energy_coef_nxt  = energy_coef_r;
    pulse_const_nxt  = pulse_const_r;
    frac_nxt         = frac_r;
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_r;
    hi_nxt           = hi_r;
    lo_nxt           = lo_r;
    mcand_nxt        = mcand_r;
    fshift_nxt       = fshift_r;
    div_nxt          = div_r;
    rem_nxt          = rem_r;
    p_nxt            = p_r;
    res_value_nxt    = res_value_r;
    res_status_nxt   = res_status_r;
    out_value_nxt    = out_value_r;
    out_status_nxt   = out_status_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;

    // Register writes must arrive only while the core is idle; the user keeps to this, the core does not enforce it
    if (cfg_wr) begin
      case (cfg_idx)
        REG_POWER_COEF:   power_coef_nxt   = pwdata[COEF_W-1:0];
        REG_CURRENT_COEF: current_coef_nxt = pwdata[COEF_W-1:0];
        REG_VOLTAGE_COEF: voltage_coef_nxt = pwdata[COEF_W-1:0];
        REG_ENERGY_COEF:  energy_coef_nxt  = pwdata[COEF_W-1:0];
        REG_PULSE_CONST:  pulse_const_nxt  = pwdata[COEF_W-1:0];
        default:          ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          hi_nxt         = '0;
          res_value_nxt  = '0;
          res_status_nxt = 1'b0;
          state_nxt      = ST_FIN;
          case (mode_t'(in_ch.mode))
            MODE_POWER: begin
              // Bad coefficient: zero power, ok status
              if (!coef_invalid(power_coef_r)) begin
                lo_nxt    = {{(MUL_W-RAW_W){1'b0}}, mag};
                mcand_nxt = {{(MCAND_W-20){1'b0}}, coef10};
                phase_nxt = PH_PWR;
                cnt_nxt   = CNT_W'(RMS_STEPS - 1);
                state_nxt = ST_MUL;
              end
            end
            MODE_CURRENT: begin
              if (coef_invalid(current_coef_r)) begin
                res_status_nxt = 1'b1;
              end else if (!in_ch.raw_reading[23]) begin
                lo_nxt    = {{(MUL_W-RAW_W){1'b0}}, in_ch.raw_reading};
                mcand_nxt = {{(MCAND_W-COEF_W){1'b0}}, current_coef_r};
                phase_nxt = PH_CUR;
                cnt_nxt   = CNT_W'(RMS_STEPS - 1);
                state_nxt = ST_MUL;
              end
            end
            MODE_VOLTAGE: begin
              if (coef_invalid(voltage_coef_r)) begin
                res_status_nxt = 1'b1;
              end else if (!in_ch.raw_reading[23]) begin
                lo_nxt    = {{(MUL_W-RAW_W){1'b0}}, in_ch.raw_reading};
                mcand_nxt = {{(MCAND_W-COEF_W){1'b0}}, voltage_coef_r};
                phase_nxt = PH_VOLT;
                cnt_nxt   = CNT_W'(RMS_STEPS - 1);
                state_nxt = ST_MUL;
              end
            end
            MODE_ENERGY: begin
              // No pulses or a zero coefficient: zero energy, fraction held
              if ((pulses != '0) && (energy_coef_r != '0) && (pulse_const_r != '0)) begin
                p_nxt     = pulses;
                lo_nxt    = {{(MUL_W-COEF_W){1'b0}}, pulse_const_r};
                mcand_nxt = {{(MCAND_W-COEF_W){1'b0}}, energy_coef_r};
                phase_nxt = PH_E1;
                cnt_nxt   = CNT_W'(E1_STEPS - 1);
                state_nxt = ST_MUL;
              end
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_MUL: begin
        // Shift the product right by one digit; finished bits move into lo
        hi_nxt     = {2'b00, sum[ACC_W-1:2]};
        lo_nxt     = {sum[1:0], lo_r[MUL_W-1:2]};
        fshift_nxt = {2'b00, fshift_r[FRAC_W-1:2]};
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_POST;
        end
      end

      ST_POST: begin
        res_value_nxt  = '0;
        res_status_nxt = 1'b0;
        state_nxt      = ST_FIN;
        case (phase_r)
          PH_PWR: begin
            // Drop readings under the noise floor, clip at full scale
            if (pwr_v < NOISE_FLOOR) begin
              res_value_nxt = '0;
            end else if (pwr_v > POWER_MAX) begin
              res_value_nxt = {{(VALUE_W-21){1'b0}}, POWER_MAX};
            end else begin
              res_value_nxt = {{(VALUE_W-21){1'b0}}, pwr_v};
            end
          end
          PH_CUR: begin
            if (cur_v[24:16] != '0) begin
              res_status_nxt = 1'b1;
            end else begin
              res_value_nxt = {{(VALUE_W-25){1'b0}}, cur_v};
            end
          end
          PH_VOLT: begin
            // Anything at or above 5*3001 is over 3000 V after the divide
            if (volt_y >= VOLT_Y_FAIL) begin
              res_status_nxt = 1'b1;
            end else begin
              div_nxt   = volt_y[DIV_W-1:0];
              rem_nxt   = '0;
              cnt_nxt   = CNT_W'(DIV_W - 1);
              state_nxt = ST_DIV;
            end
          end
          PH_E1: begin
            hi_nxt    = '0;
            lo_nxt    = {{(MUL_W-32){1'b0}}, prod[71:40]};
            mcand_nxt = p_r;
            phase_nxt = PH_E2;
            cnt_nxt   = CNT_W'(E2_STEPS - 1);
            state_nxt = ST_MUL;
          end
          PH_E2: begin
            hi_nxt     = '0;
            lo_nxt     = prod[79:24];
            mcand_nxt  = {{(MCAND_W-18){1'b0}}, ENERGY_NUM};
            fshift_nxt = frac_r;
            phase_nxt  = PH_E3;
            cnt_nxt    = CNT_W'(E3_STEPS - 1);
            state_nxt  = ST_MUL;
          end
          PH_E3: begin
            // Integer part out, fraction kept for the next pulse count
            res_value_nxt = prod[FRAC_W+VALUE_W-1:FRAC_W];
            frac_nxt      = prod[FRAC_W-1:0];
          end
          default: state_nxt = ST_FIN;
        endcase
      end

      ST_DIV: begin
        div_nxt = div_step;
        rem_nxt = dge ? dsub[2:0] : dt[2:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_value_nxt  = {{(VALUE_W-DIV_W){1'b0}}, div_step};
          res_status_nxt = 1'b0;
          state_nxt      = ST_FIN;
        end
      end

      ST_FIN: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_coef_r   <= '0;
      current_coef_r <= '0;
      voltage_coef_r <= '0;
      energy_coef_r  <= ENERGY_COEF_RST;
      pulse_const_r  <= '0;
      frac_r         <= '0;
      state_r        <= ST_IDLE;
      phase_r        <= PH_PWR;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      power_coef_r   <= power_coef_nxt;
      current_coef_r <= current_coef_nxt;
      voltage_coef_r <= voltage_coef_nxt;
      energy_coef_r  <= energy_coef_nxt;
      pulse_const_r  <= pulse_const_nxt;
      frac_r         <= frac_nxt;
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      cnt_r          <= cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    mcand_r      <= mcand_nxt;
    fshift_r     <= fshift_nxt;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    p_r          <= p_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

@@ tb/meter_reading_converter_core_test.sv @@
module meter_reading_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrc_pkg::*;

  // Status codes on the result channel
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Scaling constants of the conversion
  localparam logic [63:0] POWER_ROUND  = 64'd1 << 31;
  localparam logic [63:0] CURRENT_HALF = 64'd1 << 23;
  localparam logic [63:0] VOLT_DEN     = 64'd41943040;   // 10 * 2^22
  localparam logic [63:0] VOLT_LIMIT   = 64'd3000;
  localparam logic [63:0] CURRENT_MAX  = 64'hFFFF;
  localparam logic [63:0] POWER_FLOOR  = 64'd20;
  localparam logic [63:0] POWER_SAT    = 64'hFFFF;
  localparam logic [63:0] PULSE_SCALE  = 64'd140625;
  localparam logic [63:0] FRAC_MASK    = (64'd1 << FRAC_W) - 64'd1;
  localparam logic [COEF_W-1:0] COEF_SENTINEL = 16'hFFFF;

  // Run control: the hold-off must stay well under the stall limit, which covers
  // the longest random stall plus the energy path several times over.
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 5000;
  localparam int BLOCK_ITEMS  = 122;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } conversion_t;

  typedef struct packed {
    mode_t              mode;
    logic [RAW_W-1:0]   raw;
    logic               known;       // result typed into the table
    logic [VALUE_W-1:0] want_value;
    logic               want_status;
  } reading_t;

  typedef enum logic {
    STEP_WRITE,
    STEP_READING
  } step_kind_t;

  typedef struct packed {
    step_kind_t        kind;
    reg_idx_t          idx;
    logic [COEF_W-1:0] coef;
    reading_t          item;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  mrc_in_if  in_bus ();
  mrc_out_if out_bus ();

  meter_reading_converter_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the calibration registers and the carried energy fraction
  logic [COEF_W-1:0] cfg_power   = '0;
  logic [COEF_W-1:0] cfg_current = '0;
  logic [COEF_W-1:0] cfg_voltage = '0;
  logic [COEF_W-1:0] cfg_energy  = ENERGY_COEF_RST;
  logic [COEF_W-1:0] cfg_pulse   = '0;
  logic [FRAC_W-1:0] energy_fraction = '0;

  reading_t    pending_readings[$];      // readings not yet taken by the block
  conversion_t expected_conversions[$];  // results owed by the block, oldest first
  step_t       directed_steps[$];

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 71;
  logic        hold_results  = 1'b0;
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic coef_unusable(input logic [COEF_W-1:0] c);
    return (c == '0) || (c == COEF_SENTINEL);
  endfunction

  // Convert one reading the way the block should, advancing the energy fraction.
  function automatic conversion_t convert_reading(input mode_t mode,
                                                  input logic [RAW_W-1:0] raw);
    conversion_t       res;
    logic [63:0]       mag, acc, whole, part, sum, limit;
    logic [COEF_W-1:0] coef;
    res.value  = '0;
    res.status = STATUS_OK;
    case (mode)
      MODE_POWER: begin
        // Bad coefficient reads as zero power, never as a failure
        if (!coef_unusable(cfg_power)) begin
          mag = {32'd0, raw[31] ? (~raw + 32'd1) : raw};
          acc = (mag * cfg_power * 64'd10 + POWER_ROUND) >> 32;
          if (acc < POWER_FLOOR) acc = '0;
          else if (acc > POWER_SAT) acc = POWER_SAT;
          res.value = acc[VALUE_W-1:0];
        end
      end
      MODE_CURRENT, MODE_VOLTAGE: begin
        coef = (mode == MODE_CURRENT) ? cfg_current : cfg_voltage;
        if (coef_unusable(coef)) begin
          res.status = STATUS_FAIL;
        end else if (!raw[23]) begin
          // Bit 23 set means a zero reading; skip the scaling entirely
          if (mode == MODE_CURRENT) begin
            acc   = ({32'd0, raw} * coef + CURRENT_HALF) >> 24;
            limit = CURRENT_MAX;
          end else begin
            acc   = ({32'd0, raw} * coef + VOLT_DEN / 2) / VOLT_DEN;
            limit = VOLT_LIMIT;
          end
          if (acc > limit) res.status = STATUS_FAIL;
          else res.value = acc[VALUE_W-1:0];
        end
      end
      MODE_ENERGY: begin
        // Idle energy leaves the fraction alone
        if (raw != '0 && cfg_energy != '0 && cfg_pulse != '0) begin
          acc   = {40'd0, raw[PULSE_W-1:0]} * cfg_energy * cfg_pulse;
          whole = acc >> FRAC_W;
          part  = acc & FRAC_MASK;
          sum   = part * PULSE_SCALE + {30'd0, energy_fraction};
          energy_fraction = sum[FRAC_W-1:0];
          acc   = whole * PULSE_SCALE + (sum >> FRAC_W);
          res.value = acc[VALUE_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Largest reading whose product with coef stays within num, capped to 32 bits
  function automatic logic [31:0] span_below(input logic [63:0] num,
                                             input logic [COEF_W-1:0] coef);
    logic [63:0] q;
    q = num / ((coef == '0) ? 64'd1 : {48'd0, coef});
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Mostly usable coefficients, with the sentinels and edges mixed in
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COEF_SENTINEL;
      2:       return 16'd1;
      3:       return 16'hFFFE;
      default: return COEF_W'($urandom_range(65535));
    endcase
  endfunction

  // Random reading shaped so most of them land inside the conversion's range
  function automatic reading_t make_reading();
    reading_t    r;
    logic [31:0] span;
    r      = '0;
    r.mode = mode_t'($urandom_range(3));
    r.raw  = $urandom;
    case (r.mode)
      MODE_POWER: begin
        if ($urandom_range(2) != 0) begin
          // Either up to just past saturation, or around the noise floor
          span = span_below(($urandom_range(1) ? 64'd7000 : 64'd3) << 32, cfg_power);
          if (span > 32'h8000_0000) span = 32'h8000_0000;
          r.raw = $urandom_range(span);
          if ($urandom_range(1) != 0) r.raw = -r.raw;
        end
      end
      MODE_CURRENT: begin
        if ($urandom_range(2) != 0) begin
          r.raw = $urandom_range(span_below(64'd70000 << 24, cfg_current));
          if ($urandom_range(3) != 0) r.raw[23] = 1'b0;
        end
      end
      MODE_VOLTAGE: begin
        if ($urandom_range(2) != 0) begin
          r.raw = $urandom_range(span_below(64'd3100 * VOLT_DEN, cfg_voltage));
          if ($urandom_range(3) != 0) r.raw[23] = 1'b0;
        end
      end
      MODE_ENERGY: begin
        case ($urandom_range(7))
          0:       r.raw = '0;
          1, 2, 3: r.raw = $urandom_range(200, 1);   // small counts build up the fraction
          4, 5:    r.raw = $urandom_range(24'hFFFFFF);
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_write(input reg_idx_t idx, input logic [COEF_W-1:0] coef);
    step_t s;
    s      = '0;
    s.kind = STEP_WRITE;
    s.idx  = idx;
    s.coef = coef;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_reading(input mode_t mode, input logic [RAW_W-1:0] raw);
    step_t s;
    s          = '0;
    s.kind     = STEP_READING;
    s.item.mode = mode;
    s.item.raw  = raw;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_known(input mode_t mode, input logic [RAW_W-1:0] raw,
                                    input logic [VALUE_W-1:0] value, input logic status);
    step_t s;
    s                  = '0;
    s.kind             = STEP_READING;
    s.item.mode        = mode;
    s.item.raw         = raw;
    s.item.known       = 1'b1;
    s.item.want_value  = value;
    s.item.want_status = status;
    directed_steps.push_back(s);
  endfunction

  function automatic void note_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
  endfunction

  // Hold the sender until every reading is taken and every result checked.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_readings.size() != 0 || in_bus.valid || expected_conversions.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then idle with psel low so back-to-back writes never
  // lower and raise psel in the same step.
  task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] coef);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, coef};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POWER_COEF:   cfg_power   = coef;
      REG_CURRENT_COEF: cfg_current = coef;
      REG_VOLTAGE_COEF: cfg_voltage = coef;
      REG_ENERGY_COEF:  cfg_energy  = coef;
      REG_PULSE_CONST:  cfg_pulse   = coef;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Input side: on each accepted beat predict its result, then offer the next
  // reading or idle. A beat that is not taken stays on the bus unchanged.
  always @(posedge clk) begin : offer_readings
    reading_t    beat;
    conversion_t calc;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        beat = pending_readings.pop_front();
        calc = convert_reading(beat.mode, beat.raw);
        if (beat.known) begin
          calc.value  = beat.want_value;
          calc.status = beat.want_status;
        end
        expected_conversions.push_back(calc);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid       <= 1'b1;
          in_bus.mode        <= pending_readings[0].mode;
          in_bus.raw_reading <= pending_readings[0].raw;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each accepted beat against the oldest expectation,
  // then decide ready for the next edge.
  always @(posedge clk) begin : take_results
    conversion_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_conversions.size() == 0) begin
          note_mismatch("unexpected beat", '0, out_bus.value);
        end else begin
          want = expected_conversions.pop_front();
          if (out_bus.value !== want.value) note_mismatch("value", want.value, out_bus.value);
          if (out_bus.status !== want.status)
            note_mismatch("status", VALUE_W'(want.status), VALUE_W'(out_bus.status));
        end
      end
      out_bus.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drop the run if neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (!rst_n || psel || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t step;
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_POWER;
    in_bus.raw_reading = '0;
    out_bus.ready      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: zero coefficients fail current and voltage, zero power,
    // and a zero pulse constant idles energy.
    add_known(MODE_POWER,   32'h1234_5678, '0, STATUS_OK);
    add_known(MODE_CURRENT, 32'h0000_1000, '0, STATUS_FAIL);
    add_known(MODE_VOLTAGE, 32'h0000_1000, '0, STATUS_FAIL);
    add_known(MODE_ENERGY,  32'h00FF_FFFF, '0, STATUS_OK);

    // All-ones sentinel coefficients and a zero energy coefficient
    add_write(REG_POWER_COEF,   16'hFFFF);
    add_write(REG_CURRENT_COEF, 16'hFFFF);
    add_write(REG_VOLTAGE_COEF, 16'hFFFF);
    add_write(REG_ENERGY_COEF,  16'h0000);
    add_write(REG_PULSE_CONST,  16'h0001);
    add_known(MODE_POWER,   32'h7FFF_FFFF, '0, STATUS_OK);
    add_known(MODE_CURRENT, 32'h0000_0000, '0, STATUS_FAIL);
    add_known(MODE_VOLTAGE, 32'hFFFF_FFFF, '0, STATUS_FAIL);
    add_known(MODE_ENERGY,  32'h00FF_FFFF, '0, STATUS_OK);

    // Largest usable coefficients
    add_write(REG_POWER_COEF,   16'hFFFE);
    add_write(REG_CURRENT_COEF, 16'hFFFE);
    add_write(REG_VOLTAGE_COEF, 16'hFFFE);
    add_write(REG_ENERGY_COEF,  16'hFFFF);
    add_write(REG_PULSE_CONST,  16'hFFFF);
    // Saturation at both signed extremes, smallest magnitude, noise floor edges
    add_known(MODE_POWER, 32'h7FFF_FFFF, 40'd65535, STATUS_OK);
    add_known(MODE_POWER, 32'h8000_0000, 40'd65535, STATUS_OK);
    add_known(MODE_POWER, 32'hFFFF_FFFF, '0, STATUS_OK);
    add_reading(MODE_POWER, 32'h0001_F338);
    add_reading(MODE_POWER, 32'h0001_F32E);
    add_reading(MODE_POWER, 32'hFFFE_0CC8);
    // Zero flag wins over the range check; then the current limit edge
    add_known(MODE_CURRENT, 32'h0080_0000, '0, STATUS_OK);
    add_known(MODE_CURRENT, 32'hFFFF_FFFF, '0, STATUS_OK);
    add_reading(MODE_CURRENT, 32'h007F_FFFF);
    add_known(MODE_CURRENT, 32'h0101_0000, '0, STATUS_FAIL);
    // Voltage zero flag, the 3000 V edge and an overrange reading
    add_known(MODE_VOLTAGE, 32'h0080_0000, '0, STATUS_OK);
    add_reading(MODE_VOLTAGE, 32'h001D_4C00);
    add_known(MODE_VOLTAGE, 32'h007F_0000, '0, STATUS_FAIL);
    // Full pulse count, upper bits only, single pulse, zero count
    add_reading(MODE_ENERGY, 32'h00FF_FFFF);
    add_known(MODE_ENERGY, 32'hFF00_0000, '0, STATUS_OK);
    add_reading(MODE_ENERGY, 32'h0000_0001);
    add_known(MODE_ENERGY, 32'h0000_0000, '0, STATUS_OK);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      if (step.kind == STEP_WRITE) begin
        wait_drained();
        write_reg(step.idx, step.coef);
      end else begin
        pending_readings.push_back(step.item);
      end
    end

    // Random part: three idling profiles, each over several register settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct <= (phase == 0) ? 38 : (phase == 1) ? 71 : 0;
      recv_idle_pct <= (phase == 0) ? 71 : (phase == 1) ? 38 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        // Registers change only with the block idle
        wait_drained();
        for (int r = REG_POWER_COEF; r <= REG_PULSE_CONST; r++)
          write_reg(reg_idx_t'(r), pick_coef());
        if (phase == 0 && blk == 1) begin
          // Stall the result side while readings keep coming, to back up the input
          fork
            begin
              hold_results <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              hold_results <= 1'b0;
            end
          join_none
        end
        repeat (BLOCK_ITEMS) pending_readings.push_back(make_reading());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/mrc_pkg.sv
design/mrc_if.sv
design/meter_reading_converter_core.sv
tb/meter_reading_converter_core_test.sv
